// File: hdl/acm_pkg.sv
package acm_pkg;

  localparam int unsigned UNITY16 = 65536;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_START = 2'd1,
    KIND_TABLE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_SMOOTH = 2'd1,
    CURVE_EQPOW  = 2'd2,
    CURVE_CUSTOM = 2'd3
  } curve_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] outgoing_left;
    logic signed [23:0] outgoing_right;
    logic signed [23:0] incoming_left;
    logic signed [23:0] incoming_right;
    logic [1:0]         fade_curve;
    logic [31:0]        fade_length;
    logic               table_side;
    logic [5:0]         table_index;
    logic [16:0]        table_value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] mixed_left;
    logic signed [23:0] mixed_right;
    logic               fade_active;
    logic [16:0]        fade_position;
  } out_item_t;

  // divider control between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  // equal-power ROM, first half; second half is mirrored
  function automatic logic [16:0] ep_rom(input logic [5:0] k);
    logic [16:0] r;
    case (k)
      6'd0: r = 17'd0;       6'd1: r = 17'd1570;    6'd2: r = 17'd3069;
      6'd3: r = 17'd4502;    6'd4: r = 17'd5876;    6'd5: r = 17'd7196;
      6'd6: r = 17'd8466;    6'd7: r = 17'd9690;    6'd8: r = 17'd10873;
      6'd9: r = 17'd12018;   6'd10: r = 17'd13128;  6'd11: r = 17'd14205;
      6'd12: r = 17'd15253;  6'd13: r = 17'd16274;  6'd14: r = 17'd17270;
      6'd15: r = 17'd18243;  6'd16: r = 17'd19195;  6'd17: r = 17'd20128;
      6'd18: r = 17'd21043;  6'd19: r = 17'd21943;  6'd20: r = 17'd22828;
      6'd21: r = 17'd23700;  6'd22: r = 17'd24560;  6'd23: r = 17'd25410;
      6'd24: r = 17'd26250;  6'd25: r = 17'd27082;  6'd26: r = 17'd27907;
      6'd27: r = 17'd28726;  6'd28: r = 17'd29541;  6'd29: r = 17'd30351;
      6'd30: r = 17'd31158;  6'd31: r = 17'd31964;  6'd32: r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] ep_point(input logic [6:0] k);
    logic [16:0] r;
    if (k >= 7'd64) r = 17'(UNITY16);
    else if (k <= 7'd32) r = ep_rom(k[5:0]);
    else r = 17'(UNITY16) - ep_rom(6'(7'd64 - k));
    return r;
  endfunction

endpackage

// File: hdl/acm_ram.sv
module acm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/acm_div.sv
// restoring divider, one quotient bit a cycle
module acm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  acm_pkg::div_req_t  req,
  output logic               done,
  output logic [47:0]        quot
);
  import acm_pkg::*;

  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[47]};
    if (busy_r) begin
      q_nxt = {q_r[46:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= 6'd48;
      q_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !req.start |=> !busy_r) else $error("divider started itself");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'd48) else $error("divider count out of range");
`endif
endmodule

// File: hdl/audio_crossfade_mixer.sv
// Stereo crossfader. Each frame item is mixed as outgoing*gain_out +
// incoming*gain_in with rounding and saturation; start items set the curve
// and length, table items write the custom gain curve. Frame items run a
// 48-step restoring divider for the progress, then the gain curve and a
// four-step shared mix; a frame at zero length skips the divider and the
// curve. Start items during a fade run one divide and one multiply; start
// items while idle copy the pending table into the live table. A result
// that finds the previous one still waiting holds the block until that one
// is taken. After reset a pass loads the equal-power curve into both tables
// before any item is taken.
module audio_crossfade_mixer #(
  parameter int TABLE_POINTS = 64,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  acm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acm_pkg::out_item_t  out_data
);
  import acm_pkg::*;

  localparam int DEPTH = 2 * TABLE_POINTS;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS) : 1;
  localparam int GW = GAIN_FRAC_BITS + 2;
  localparam int UQ = UNITY16 / (TABLE_POINTS - 1);
  localparam int UR = UNITY16 % (TABLE_POINTS - 1);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_TWRITE, S_COPY_R, S_COPY_W,
    S_DIV, S_CARRY, S_CARRY_MUL, S_CURVE, S_SM1, S_SM2, S_EP,
    S_TB_R0, S_TB_R1, S_TB_R2, S_TB_R3, S_TB_A, S_TB_B,
    S_MIX0, S_MIX1, S_MIX2, S_MIX3, S_OUT
  } state_t;

  state_t state_r;
  in_item_t item_r;
  logic [1:0]  mode_r;
  logic [31:0] len_r, elap_r;
  logic        run_r;
  logic [AW:0] ptr_r;
  logic [16:0] p_r, gi_r, go_r;
  logic [16:0] ta_r, tb_r;
  logic [16:0] tfrac_r;
  logic [63:0] prod_r;
  logic signed [49:0] acc_r;
  logic        is_start_r;
  logic signed [23:0] left_r;
  logic [16:0] iu_r;
  logic [8:0]  irem_r;
  out_item_t   out_r;
  logic        out_v_r;

  div_req_t dreq;
  logic div_done;
  logic [47:0] div_q;

  // memories: live and pending gain tables
  logic live_we, pend_we;
  logic [AW-1:0] live_wa, live_ra, pend_wa, pend_ra;
  logic [16:0] live_wd, pend_wd, live_rd, pend_rd;

  acm_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_live (
    .clk, .we(live_we), .waddr(live_wa), .wdata(live_wd),
    .raddr(live_ra), .rdata(live_rd));
  acm_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_pend (
    .clk, .we(pend_we), .waddr(pend_wa), .wdata(pend_wd),
    .raddr(pend_ra), .rdata(pend_rd));
  acm_div u_div (.clk, .rst_n, .req(dreq), .done(div_done), .quot(div_q));

  // shared multiplier, operands chosen by state
  logic [31:0] ma, mb;
  logic [16:0] p_clamp;
  logic [16:0] ep_a, ep_b;
  logic [6:0]  ep_i;

  assign p_clamp = (div_q > 48'(UNITY16)) ? 17'(UNITY16) : div_q[16:0];
  assign ep_i = p_r[16:10];
  assign ep_a = ep_point(ep_i);
  assign ep_b = ep_point(ep_i + 7'd1);

  function automatic logic [GW-1:0] to_gain(input logic [16:0] g);
    logic [GW+15:0] w;
    if (GAIN_FRAC_BITS >= 16) w = (GW+16)'(g) << (GAIN_FRAC_BITS - 16);
    else w = ((GW+16)'(g) + ((GW+16)'(1) << (15 - GAIN_FRAC_BITS)))
             >> (16 - GAIN_FRAC_BITS);
    return w[GW-1:0];
  endfunction

  logic [GW-1:0] gin_q, gout_q;
  assign gin_q = to_gain(gi_r);
  assign gout_q = to_gain(go_r);

  logic signed [23:0] samp;
  logic [GW-1:0] gsel;
  logic signed [GW+24:0] smul;
  always_comb begin
    unique case (state_r)
      S_MIX0: begin samp = item_r.outgoing_left;  gsel = gout_q; end
      S_MIX1: begin samp = item_r.incoming_left;  gsel = gin_q;  end
      S_MIX2: begin samp = item_r.outgoing_right; gsel = gout_q; end
      S_MIX3: begin samp = item_r.incoming_right; gsel = gin_q;  end
      default: begin samp = '0; gsel = '0; end
    endcase
    smul = samp * $signed({1'b0, gsel});
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_CARRY: begin ma = 32'(p_r); mb = len_r; end
      S_CURVE: begin
        ma = 32'(p_r);
        mb = (mode_r == CURVE_CUSTOM) ? 32'(TABLE_POINTS - 1) : 32'(p_r);
      end
      S_SM1: begin ma = prod_r[47:16] + 32'(prod_r[15]);
        mb = 32'd196608 - 32'({p_r, 1'b0}); end
      default: ;
    endcase
  end

  logic [63:0] mul;
  assign mul = ma * mb;

  // saturate the rounded sum
  logic signed [49:0] rnd;
  logic signed [23:0] sat;
  assign rnd = (acc_r + (50'sd1 <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
  assign sat = (rnd > 50'sd8388607) ? 24'sh7fffff :
               (rnd < -50'sd8388608) ? 24'sh800000 : rnd[23:0];

  logic [AW-1:0] tb_lo;
  logic [PW:0] clamp_idx;
  logic [AW-1:0] copy_addr;
  assign copy_addr = ptr_r[AW-1:0];

  always_comb begin
    clamp_idx = (prod_r[31:16] > 16'(TABLE_POINTS - 2)) ?
                (PW+1)'(TABLE_POINTS - 2) : prod_r[PW+16:16];
    tb_lo = AW'(clamp_idx);
  end

  // reset pass: two entries per point, u stepped by a running remainder
  logic [AW-1:0] init_addr;
  logic [16:0] ia, ib, igi, init_val;
  logic [27:0] isum;
  logic [8:0]  irem_sum;
  logic        icarry;
  assign init_addr = ptr_r[0] ? AW'(TABLE_POINTS) + ptr_r[AW:1] : ptr_r[AW:1];
  assign ia = ep_point(iu_r[16:10]);
  assign ib = ep_point(iu_r[16:10] + 7'd1);
  assign isum = 28'(ia) * (28'd1024 - 28'(iu_r[9:0])) + 28'(ib) * 28'(iu_r[9:0])
                + 28'd512;
  assign igi = (iu_r[16:10] >= 7'd64) ? 17'(UNITY16) : isum[26:10];
  assign init_val = ptr_r[0] ? igi : 17'(UNITY16) - igi;
  assign irem_sum = irem_r + 9'(UR);
  assign icarry = (irem_sum >= 9'(TABLE_POINTS - 1));

  always_comb begin
    dreq = '0;
    if (state_r == S_IDLE && in_valid && in_ready &&
        ((in_data.kind == KIND_FRAME && len_r != 32'd0) ||
         (in_data.kind == KIND_START && run_r)))
      dreq = '{start: 1'b1, num: {elap_r, 16'd0}, den: len_r};
  end

  logic [27:0] esum;
  logic [16:0] egi;
  assign esum = 28'(ep_a) * (28'd1024 - 28'(p_r[9:0])) + 28'(ep_b) * 28'(p_r[9:0])
                + 28'd512;
  assign egi = (ep_i >= 7'd64) ? 17'(UNITY16) : esum[26:10];

  always_comb begin
    live_we = 1'b0; pend_we = 1'b0;
    live_wa = init_addr; pend_wa = init_addr;
    live_wd = init_val; pend_wd = init_val;
    live_ra = '0; pend_ra = copy_addr;
    unique case (state_r)
      S_INIT: begin live_we = 1'b1; pend_we = 1'b1; end
      S_TWRITE: begin
        pend_we = (int'(item_r.table_index) < TABLE_POINTS);
        live_we = pend_we && !run_r;
        pend_wa = (item_r.table_side ? AW'(TABLE_POINTS) : AW'(0)) +
                  AW'(item_r.table_index);
        live_wa = pend_wa;
        pend_wd = item_r.table_value; live_wd = item_r.table_value;
      end
      S_COPY_W: begin
        live_we = 1'b1; live_wa = copy_addr - AW'(1); live_wd = pend_rd;
      end
      S_TB_R0: live_ra = tb_lo;
      S_TB_R1: live_ra = tb_lo + AW'(1);
      S_TB_R2: live_ra = AW'(TABLE_POINTS) + tb_lo;
      S_TB_R3: live_ra = AW'(TABLE_POINTS) + tb_lo + AW'(1);
      default: ;
    endcase
  end

  logic [31:0] elap_step;
  logic        fade_end;
  logic        out_free;
  assign elap_step = elap_r + 32'(elap_r < len_r);
  assign fade_end = (len_r != 32'd0) && (elap_step >= len_r);
  assign out_free = !out_v_r || out_ready;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ptr_r <= '0;
      iu_r <= '0;
      irem_r <= '0;
      mode_r <= CURVE_EQPOW;
      len_r <= '0;
      elap_r <= '0;
      run_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          if (ptr_r[0]) begin
            iu_r <= iu_r + 17'(UQ) + 17'(icarry);
            irem_r <= icarry ? irem_sum - 9'(TABLE_POINTS - 1) : irem_sum;
          end
          if (ptr_r == (AW+1)'(DEPTH - 1)) begin
            ptr_r <= '0;
            state_r <= S_IDLE;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        S_IDLE: if (in_valid) begin
          item_r <= in_data;
          is_start_r <= 1'b0;
          unique case (in_data.kind)
            KIND_FRAME: begin
              if (len_r == 32'd0) begin
                gi_r <= 17'd0; go_r <= 17'(UNITY16); p_r <= '0;
                state_r <= S_MIX0;
              end else state_r <= S_DIV;
            end
            KIND_START: begin
              mode_r <= in_data.fade_curve;
              len_r <= in_data.fade_length;
              run_r <= (in_data.fade_length != 32'd0);
              if (run_r) begin
                is_start_r <= 1'b1;
                state_r <= S_DIV;
              end else begin
                elap_r <= '0;
                ptr_r <= '0;
                state_r <= S_COPY_R;
              end
            end
            KIND_TABLE: state_r <= S_TWRITE;
            default: state_r <= S_IDLE;
          endcase
        end
        S_TWRITE: state_r <= S_IDLE;
        S_COPY_R: begin ptr_r <= ptr_r + 1'b1; state_r <= S_COPY_W; end
        S_COPY_W: begin
          if (ptr_r == (AW+1)'(DEPTH)) state_r <= S_IDLE;
          else state_r <= S_COPY_R;
        end
        S_DIV: if (div_done) begin
          p_r <= p_clamp;
          state_r <= is_start_r ? S_CARRY : S_CURVE;
        end
        S_CARRY: begin prod_r <= mul; state_r <= S_CARRY_MUL; end
        S_CARRY_MUL: begin elap_r <= prod_r[47:16]; state_r <= S_IDLE; end
        S_CURVE: begin
          prod_r <= mul;
          unique case (mode_r)
            CURVE_LINEAR: begin gi_r <= p_r; go_r <= 17'(UNITY16) - p_r;
              state_r <= S_MIX0; end
            CURVE_SMOOTH: state_r <= S_SM1;
            CURVE_EQPOW: state_r <= S_EP;
            default: state_r <= S_TB_R0;
          endcase
        end
        S_SM1: begin prod_r <= mul; state_r <= S_SM2; end
        S_SM2: begin
          gi_r <= 17'((prod_r + 64'd32768) >> 16);
          go_r <= 17'(UNITY16) - 17'((prod_r + 64'd32768) >> 16);
          state_r <= S_MIX0;
        end
        S_EP: begin
          gi_r <= egi;
          go_r <= 17'(UNITY16) - egi;
          state_r <= S_MIX0;
        end
        S_TB_R0: begin
          tfrac_r <= 17'(prod_r[31:0] - (32'(clamp_idx) << 16));
          state_r <= S_TB_R1;
        end
        S_TB_R1: begin ta_r <= live_rd; state_r <= S_TB_R2; end
        S_TB_R2: begin tb_r <= live_rd; state_r <= S_TB_R3; end
        S_TB_R3: begin
          // outgoing side: a*(1-f)+b*f
          acc_r <= 50'(ta_r) * (50'd65536 - 50'(tfrac_r)) + 50'(tb_r) * 50'(tfrac_r);
          ta_r <= live_rd;
          state_r <= S_TB_A;
        end
        S_TB_A: begin
          go_r <= 17'((acc_r + 50'sd32768) >>> 16);
          tb_r <= live_rd;
          state_r <= S_TB_B;
        end
        S_TB_B: begin
          gi_r <= 17'((50'(ta_r) * (50'd65536 - 50'(tfrac_r)) + 50'(tb_r) * 50'(tfrac_r)
                      + 50'd32768) >> 16);
          state_r <= S_MIX0;
        end
        S_MIX0: begin acc_r <= 50'(smul); state_r <= S_MIX1; end
        S_MIX1: begin acc_r <= acc_r + 50'(smul); state_r <= S_MIX2; end
        S_MIX2: begin
          left_r <= sat;
          acc_r <= 50'(smul);
          state_r <= S_MIX3;
        end
        S_MIX3: begin acc_r <= acc_r + 50'(smul); state_r <= S_OUT; end
        S_OUT: if (out_free) begin
          out_r.mixed_left <= left_r;
          out_r.mixed_right <= sat;
          out_r.fade_position <= (len_r == 32'd0) ? 17'd0 : p_r;
          out_r.fade_active <= run_r && !fade_end;
          if (len_r != 32'd0) begin
            elap_r <= elap_step;
            if (fade_end) run_r <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> $stable(out_r)) else $error("result changed while waiting");
  a_elap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && run_r |-> elap_r < len_r) else $error("elapsed past length");
`endif
endmodule
